FILE: hw/rtl/msc_pkg.sv
package msc_pkg;

  localparam int unsigned IdleW = 20;
  localparam int unsigned ThrW  = 8;
  localparam int unsigned AccW  = 10;
  localparam int unsigned HalfW = 8;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENTER    = 2'd0,
    CFG_EXIT     = 2'd1,
    CFG_IDLE     = 2'd2,
    CFG_DEBOUNCE = 2'd3
  } cfg_idx_e;

  localparam logic [ThrW-1:0]  EnterReset    = 8'd6;
  localparam logic [ThrW-1:0]  ExitReset     = 8'd4;
  localparam logic [IdleW-1:0] IdleReset     = 20'd100000;
  localparam logic [7:0]       DebounceReset = 8'd2;

  typedef struct packed {
    logic [ThrW-1:0]  enter_threshold;
    logic [ThrW-1:0]  exit_threshold;
    logic [IdleW-1:0] idle_limit;
    logic [7:0]       debounce_len;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [7:0]        buttons;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } in_req_t;

  typedef struct packed {
    logic [7:0]        clean_buttons;
    logic signed [7:0] out_dx;
    logic signed [7:0] out_dy;
    logic              smoothing_active;
  } out_req_t;

  typedef struct packed {
    logic motion;
    logic tick;
  } step_t;

endpackage

FILE: hw/rtl/mouse_sample_conditioner.sv
// Conditions mouse sensor requests: buttons are debounced and nonzero motion
// runs through an adaptive smoother that hysteresis switches on and off. The
// block takes one request per clock cycle unless stalled; a request is
// captured in an input register, processed against the filter state when it
// advances, and its result appears from the result register. Tick requests
// (func = 1) only advance the idle counter and produce no result. A stalled
// result holds a motion request in the input register and stalls upstream.
module mouse_sample_conditioner (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  msc_pkg::in_req_t                 in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output msc_pkg::out_req_t                out_req_o,
  input  logic                             cfg_we_i,
  input  logic [msc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [msc_pkg::CfgDataW-1:0]     cfg_data_i
);

  msc_pkg::cfg_t     cfg_q;
  msc_pkg::in_req_t  hold_q;
  msc_pkg::out_req_t res_q, res_d;
  msc_pkg::step_t    step;
  logic              hold_valid_q, res_valid_q;
  logic              advance, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_threshold <= msc_pkg::EnterReset;
      cfg_q.exit_threshold  <= msc_pkg::ExitReset;
      cfg_q.idle_limit      <= msc_pkg::IdleReset;
      cfg_q.debounce_len    <= msc_pkg::DebounceReset;
    end else if (cfg_we_i) begin
      unique case (msc_pkg::cfg_idx_e'(cfg_idx_i))
        msc_pkg::CFG_ENTER:    cfg_q.enter_threshold <= cfg_data_i[msc_pkg::ThrW-1:0];
        msc_pkg::CFG_EXIT:     cfg_q.exit_threshold  <= cfg_data_i[msc_pkg::ThrW-1:0];
        msc_pkg::CFG_IDLE:     cfg_q.idle_limit      <= cfg_data_i;
        msc_pkg::CFG_DEBOUNCE: cfg_q.debounce_len    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance    = hold_valid_q && (hold_q.func || !res_valid_q || !out_stall_i);
  assign in_stall_o = hold_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign step.motion = advance && !hold_q.func;
  assign step.tick   = advance && hold_q.func;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= accept || (hold_valid_q && !advance);
      res_valid_q  <= step.motion || (res_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= in_req_i;
    end
    if (step.motion) begin
      res_q <= res_d;
    end
  end

  msc_motion u_motion (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .dx_i     (hold_q.dx),
    .dy_i     (hold_q.dy),
    .cfg_i    (cfg_q),
    .out_dx_o (res_d.out_dx),
    .out_dy_o (res_d.out_dy),
    .active_o (res_d.smoothing_active)
  );

  msc_debounce u_debounce (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (step.motion),
    .buttons_i       (hold_q.buttons),
    .debounce_len_i  (cfg_q.debounce_len),
    .clean_buttons_o (res_d.clean_buttons)
  );

  assign out_valid_o = res_valid_q;
  assign out_req_o   = res_q;

endmodule

FILE: hw/rtl/msc_debounce.sv
module msc_debounce (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] buttons_i,
  input  logic [7:0] debounce_len_i,
  output logic [7:0] clean_buttons_o
);

  logic [7:0] stable_q, stable_d;
  logic [7:0] count_q, count_d;
  logic       differs;

  always_comb begin
    differs  = (stable_q != buttons_i);
    stable_d = stable_q;
    count_d  = count_q;
    if (differs && (count_q >= debounce_len_i)) begin
      stable_d = buttons_i;
      count_d  = '0;
    end else if (differs) begin
      if (count_q != 8'hFF) begin
        count_d = count_q + 8'd1;
      end
    end else begin
      count_d = '0;
    end
  end

  assign clean_buttons_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      count_q  <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: hw/rtl/msc_motion.sv
module msc_motion (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msc_pkg::step_t                    step_i,
  input  logic signed [7:0]                 dx_i,
  input  logic signed [7:0]                 dy_i,
  input  msc_pkg::cfg_t                     cfg_i,
  output logic signed [7:0]                 out_dx_o,
  output logic signed [7:0]                 out_dy_o,
  output logic                              active_o
);

  logic                               on_q, on_d;
  logic signed [msc_pkg::AccW-1:0]    acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic signed [msc_pkg::HalfW-1:0]   half_x_q, half_x_d, half_y_q, half_y_d;
  logic [msc_pkg::IdleW-1:0]          idle_q, idle_d;
  logic                               nonzero, timed_out, on_mid;
  logic [8:0]                         mag_x, mag_y, enter_ext, exit_ext;
  logic signed [msc_pkg::AccW-1:0]    base_acc_x, base_acc_y;
  logic signed [msc_pkg::HalfW-1:0]   base_half_x, base_half_y;
  logic signed [msc_pkg::AccW-1:0]    sum_x, sum_y, rnd_x, rnd_y;

  always_comb begin
    nonzero   = (dx_i != 8'sd0) || (dy_i != 8'sd0);
    mag_x     = dx_i[7] ? 9'(-{dx_i[7], dx_i}) : {1'b0, dx_i};
    mag_y     = dy_i[7] ? 9'(-{dy_i[7], dy_i}) : {1'b0, dy_i};
    enter_ext = {1'b0, cfg_i.enter_threshold};
    exit_ext  = {1'b0, cfg_i.exit_threshold};
    timed_out = on_q && (idle_q > cfg_i.idle_limit);
    on_mid    = on_q && !timed_out;

    base_acc_x  = timed_out ? '0 : acc_x_q;
    base_acc_y  = timed_out ? '0 : acc_y_q;
    base_half_x = timed_out ? '0 : half_x_q;
    base_half_y = timed_out ? '0 : half_y_q;

    sum_x = base_acc_x - msc_pkg::AccW'(base_half_x) + msc_pkg::AccW'(dx_i);
    sum_y = base_acc_y - msc_pkg::AccW'(base_half_y) + msc_pkg::AccW'(dy_i);
    rnd_x = sum_x + {{(msc_pkg::AccW-1){1'b0}}, sum_x[msc_pkg::AccW-1]};
    rnd_y = sum_y + {{(msc_pkg::AccW-1){1'b0}}, sum_y[msc_pkg::AccW-1]};

    on_d     = on_q;
    acc_x_d  = acc_x_q;
    acc_y_d  = acc_y_q;
    half_x_d = half_x_q;
    half_y_d = half_y_q;
    idle_d   = idle_q;
    out_dx_o = dx_i;
    out_dy_o = dy_i;

    if (step_i.tick) begin
      if (idle_q != '1) begin
        idle_d = idle_q + 1'b1;
      end
    end else if (nonzero) begin
      if (!on_mid) begin
        on_d = (mag_x > enter_ext) || (mag_y > enter_ext);
      end else begin
        on_d = !((mag_x < exit_ext) && (mag_y < exit_ext));
      end
      if (on_d) begin
        acc_x_d  = sum_x;
        acc_y_d  = sum_y;
        half_x_d = rnd_x[msc_pkg::HalfW:1];
        half_y_d = rnd_y[msc_pkg::HalfW:1];
        out_dx_o = rnd_x[msc_pkg::HalfW:1];
        out_dy_o = rnd_y[msc_pkg::HalfW:1];
        idle_d   = '0;
      end else begin
        acc_x_d  = '0;
        acc_y_d  = '0;
        half_x_d = '0;
        half_y_d = '0;
      end
    end
    active_o = on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q     <= 1'b0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      half_x_q <= '0;
      half_y_q <= '0;
      idle_q   <= '0;
    end else if (step_i.motion || step_i.tick) begin
      on_q     <= on_d;
      acc_x_q  <= acc_x_d;
      acc_y_q  <= acc_y_d;
      half_x_q <= half_x_d;
      half_y_q <= half_y_d;
      idle_q   <= idle_d;
    end
  end

endmodule
